// File: sv/stuffed_response_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// stuffed_response_deframer_unit_macros
// assertion macros shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef STUFFED_RESPONSE_DEFRAMER_UNIT_MACROS_SVH
`define STUFFED_RESPONSE_DEFRAMER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge outside reset
`define SRD_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("deframer check failed");
// antecedent at one edge implies consequent at the next edge
`define SRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define SRD_ASSERT(label, cond)
`define SRD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// types and codes of the stuffed response deframer
// ----------------------------------------------------------------------------
package srd_pkg;

  // link event kinds
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_FAIL    = 2'd2;

  // completion error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_STUFF    = 3'd1;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd2;
  localparam logic [2:0] ERR_READ     = 3'd3;
  localparam logic [2:0] ERR_SHORT    = 3'd4;
  localparam logic [2:0] ERR_ID       = 3'd5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_CAPACITY = 2'd3;

  localparam int LIMIT_W = 11;
  localparam int CAP_W   = 10;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [7:0] expected_id;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload;
    logic [7:0]       status_byte;
    logic [2:0]       error_code;
    logic [CAP_W-1:0] payload_count;
    logic             last;
  } out_item_t;

endpackage

// File: sv/srd_stream_if.sv
// ----------------------------------------------------------------------------
// srd_stream_if
// valid/ready stream channel carrying one data item
// ----------------------------------------------------------------------------
interface srd_stream_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: sv/stuffed_response_deframer_unit.sv
// ----------------------------------------------------------------------------
// stuffed_response_deframer_unit
// removes byte stuffing from a response stream, streams payload bytes and
// closes each frame with one completion report
// output: a result is registered and appears in the cycle after the request that causes it
// throughput: one request per cycle; a result held by the receiver stalls input
// reset: synchronous, clears frame state and output valid, config to defaults
// ----------------------------------------------------------------------------
`include "stuffed_response_deframer_unit_macros.svh"

module stuffed_response_deframer_unit #(
  parameter int FRAME_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srd_pkg::CFG_DATA_W-1:0] cfg_data,
  srd_stream_if.sink                     in_ch,
  srd_stream_if.source                   out_ch
);

  import srd_pkg::*;

  // the frame limit register is 11 bits, so the limit in use never exceeds
  // the smaller of that range and FRAME_BYTES; the byte counter is sized to it
  localparam int LIM_MAX = (FRAME_BYTES < 2047) ? FRAME_BYTES : 2047;
  localparam int CNT_W   = $clog2(LIM_MAX + 1);

  // configuration registers
  logic [7:0]         escape_byte;
  logic [7:0]         end_byte;
  logic [LIMIT_W-1:0] frame_limit;
  logic [CAP_W-1:0]   payload_capacity;

  // frame state
  logic               escape_pending, escape_pending_next;
  logic               error_seen, error_seen_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [7:0]         hdr_id_seen, hdr_id_seen_next;
  logic [7:0]         status_seen, status_seen_next;
  logic [CAP_W-1:0]   given_count, given_count_next;

  // output register
  logic               out_valid;
  out_item_t          out_item;

  // per-request decode
  in_item_t           req;
  logic               accept;
  logic               do_take;
  logic               do_finish;
  logic [2:0]         fin_code;
  logic [CNT_W-1:0]   limit;
  logic               overflow;
  logic               has_result;
  out_item_t          result;

  // check helpers
  logic               abort_req;
  logic               frame_idle;

  assign req    = in_ch.data;
  // the output register frees up in the same cycle it is drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

  // effective frame limit is min(frame_limit, FRAME_BYTES)
  assign limit = (int'(frame_limit) > LIM_MAX) ? CNT_W'(LIM_MAX) : CNT_W'(frame_limit);

  // classify the request: data byte to keep, frame end, or state change only
  always_comb begin
    do_take             = 1'b0;
    do_finish           = 1'b0;
    fin_code            = ERR_OK;
    escape_pending_next = escape_pending;
    error_seen_next     = error_seen;
    case (req.func)
      FUNC_TIMEOUT: begin
        do_finish = 1'b1;
        fin_code  = error_seen ? ERR_STUFF : ERR_TIMEOUT;
      end
      FUNC_FAIL: begin
        do_finish = 1'b1;
        fin_code  = ERR_READ;
      end
      FUNC_BYTE: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (req.rx_byte == end_byte) begin
            // end marker, error precedence: stuffing, short, id
            do_finish = 1'b1;
            if (error_seen) begin
              fin_code = ERR_STUFF;
            end else if (byte_count < CNT_W'(2)) begin
              fin_code = ERR_SHORT;
            end else if (hdr_id_seen != req.expected_id) begin
              fin_code = ERR_ID;
            end else begin
              fin_code = ERR_OK;
            end
          end else if (req.rx_byte != escape_byte) begin
            // bad escape sequence
            error_seen_next = 1'b1;
          end else begin
            do_take = 1'b1;
          end
        end else if (req.rx_byte == escape_byte) begin
          escape_pending_next = 1'b1;
        end else begin
          do_take = 1'b1;
        end
      end
      default: begin
        // unused event kind: no result, no state change
      end
    endcase
  end

  // data path: header capture, payload streaming, completion report
  always_comb begin
    byte_count_next    = byte_count;
    hdr_id_seen_next   = hdr_id_seen;
    status_seen_next   = status_seen;
    given_count_next   = given_count;
    overflow           = 1'b0;
    has_result         = 1'b0;
    result             = '0;
    if (do_finish) begin
      has_result           = 1'b1;
      result.kind          = 1'b1;
      result.last          = 1'b1;
      result.status_byte   = (byte_count >= CNT_W'(2)) ? status_seen : 8'h00;
      result.error_code    = fin_code;
      result.payload_count = given_count;
      byte_count_next      = '0;
      hdr_id_seen_next     = '0;
      status_seen_next     = '0;
      given_count_next     = '0;
    end else if (do_take && !error_seen) begin
      if (byte_count >= limit) begin
        // overflow drops the byte and poisons the frame
        overflow = 1'b1;
      end else begin
        byte_count_next = byte_count + CNT_W'(1);
        if (byte_count == '0) begin
          hdr_id_seen_next = req.rx_byte;
        end else if (byte_count == CNT_W'(1)) begin
          status_seen_next = req.rx_byte;
        end else if (given_count < payload_capacity) begin
          given_count_next = given_count + CAP_W'(1);
          has_result       = 1'b1;
          result.payload   = req.rx_byte;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte      <= 8'd0;
      end_byte         <= 8'd1;
      frame_limit      <= LIMIT_W'(1024);
      payload_capacity <= CAP_W'(1022);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ESCAPE_BYTE:      escape_byte      <= cfg_data[7:0];
        REG_END_BYTE:         end_byte         <= cfg_data[7:0];
        REG_FRAME_LIMIT:      frame_limit      <= cfg_data[LIMIT_W-1:0];
        REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // frame state, cleared at reset and at every completion
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      error_seen     <= 1'b0;
      byte_count     <= '0;
      hdr_id_seen    <= '0;
      status_seen    <= '0;
      given_count    <= '0;
    end else if (accept) begin
      escape_pending <= do_finish ? 1'b0 : escape_pending_next;
      error_seen     <= do_finish ? 1'b0 : (error_seen_next || overflow);
      byte_count     <= byte_count_next;
      hdr_id_seen    <= hdr_id_seen_next;
      status_seen    <= status_seen_next;
      given_count    <= given_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= has_result;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_item <= result;
    end
  end

  // checks
  assign abort_req  = accept && (req.func == FUNC_TIMEOUT || req.func == FUNC_FAIL);
  assign frame_idle = (byte_count == '0) && !escape_pending && !error_seen &&
                      (given_count == '0);

  `SRD_ASSERT(a_given_le_bytes, int'(given_count) <= int'(byte_count))
  `SRD_ASSERT_NEXT(a_abort_reports, abort_req, out_valid && out_item.last && out_item.kind)
  `SRD_ASSERT_NEXT(a_abort_clears, abort_req, frame_idle)

endmodule
